FILE: hdl/nlm_pkg.sv
// Shared constants and control/status types for the NFA line matcher.
package nlm_pkg;

    localparam int TABLE_STATES_DEF = 64;
    localparam int LINE_LENGTH_DEF  = 256;

    localparam int SUCC_W  = 7;
    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 6;
    localparam int FROM_W  = 8;
    localparam int TO_W    = 9;

    // Table entry layout in memory, lowest bits first.
    localparam int ENTRY_W = CHAR_W + 3 * SUCC_W;

    // Configuration register indexes.
    localparam logic [1:0] REG_STATES_IN_USE = 2'd0;
    localparam logic [1:0] REG_START_STATE   = 2'd1;
    localparam logic [1:0] REG_ANCHOR_START  = 2'd2;
    localparam logic [1:0] REG_ANCHOR_END    = 2'd3;

    typedef struct packed {
        logic wr_table;    // write one table entry
        logic wr_char;     // append one character to the line
        logic line_begin;  // first start position
        logic run_init;    // seed the active set for the current start
        logic scan_start;  // rewind the state scan
        logic scan_step;   // scan consumes a character (else epsilon)
        logic scan_run;    // issue table reads
        logic char_rd;     // read line character at current position
        logic char_latch;  // capture the line character
        logic step_done;   // move next set into active set
        logic next_from;   // advance start position
        logic out_hit;     // load a match result
        logic out_miss;    // load a no-match result
    } nlm_cmd_t;

    typedef struct packed {
        logic scan_busy;
        logic eps_changed;
        logic at_line_end;
        logic next_empty;
        logic hit;
        logic last_from;
        logic out_full;
        logic table_ok;
        logic line_room;
    } nlm_status_t;

endpackage

FILE: hdl/nlm_ram.sv
// Generic simple dual-port RAM with registered read.
module nlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/nlm_datapath.sv
// Datapath: table and line memories, state sets, positions and result register.
module nlm_datapath #(
    parameter int TABLE_STATES = nlm_pkg::TABLE_STATES_DEF,
    parameter int LINE_LENGTH  = nlm_pkg::LINE_LENGTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  nlm_pkg::nlm_cmd_t             cmd,
    output nlm_pkg::nlm_status_t          status,
    input  logic [nlm_pkg::INDEX_W-1:0]   entry_index,
    input  logic [nlm_pkg::CHAR_W-1:0]    entry_char,
    input  logic [nlm_pkg::SUCC_W-1:0]    next_on_match,
    input  logic [nlm_pkg::SUCC_W-1:0]    next_on_miss,
    input  logic [nlm_pkg::SUCC_W-1:0]    next_epsilon,
    input  logic [nlm_pkg::CHAR_W-1:0]    text_char,
    input  logic [nlm_pkg::SUCC_W-1:0]    used_states,
    input  logic [nlm_pkg::INDEX_W-1:0]   start_state,
    input  logic                          anchor_start,
    input  logic                          anchor_end,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic                          found,
    output logic [nlm_pkg::FROM_W-1:0]    match_from,
    output logic signed [nlm_pkg::TO_W-1:0] match_to
);
    import nlm_pkg::*;

    localparam int SW = $clog2(TABLE_STATES);
    localparam int LW = $clog2(LINE_LENGTH);

    logic [ENTRY_W-1:0]      tbl_rdata;
    logic [CHAR_W-1:0]       line_rdata;

    logic [TABLE_STATES-1:0] active_reg, active_next;
    logic [TABLE_STATES-1:0] nset_reg, nset_next;
    logic [LW-1:0]           len_reg, len_next;
    logic [LW-1:0]           pos_reg, pos_next;
    logic [LW-1:0]           from_reg, from_next;
    logic [LW-1:0]           end1_reg, end1_next;
    logic                    acc_reg, acc_next;
    logic                    chg_reg, chg_next;
    logic                    step_reg, step_next;
    logic [CHAR_W-1:0]       c_reg, c_next;
    logic [SUCC_W-1:0]       cnt_reg, cnt_next;
    logic                    pv_reg, pv_next;
    logic [SW-1:0]           jd_reg, jd_next;
    logic                    ov_reg, ov_next;
    logic                    of_reg, of_next;
    logic [FROM_W-1:0]       ofrom_reg, ofrom_next;
    logic [TO_W-1:0]         oto_reg, oto_next;

    logic                    issue;
    logic [SUCC_W-1:0]       sel;
    logic                    take, s_acc, s_move;
    logic [SW-1:0]           s_idx;

    nlm_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_STATES)) u_table (
        .aclk  (aclk),
        .we    (cmd.wr_table && status.table_ok),
        .waddr (entry_index[SW-1:0]),
        .wdata ({next_epsilon, next_on_miss, next_on_match, entry_char}),
        .raddr (cnt_reg[SW-1:0]),
        .rdata (tbl_rdata)
    );

    nlm_ram #(.WIDTH(CHAR_W), .DEPTH(LINE_LENGTH)) u_line (
        .aclk  (aclk),
        .we    (cmd.wr_char && status.line_room),
        .waddr (len_reg),
        .wdata (text_char),
        .raddr (pos_reg),
        .rdata (line_rdata)
    );

    assign issue  = cmd.scan_run && (cnt_reg < used_states);

    // Successor picked by the entry whose data just came back.
    always_comb begin
        if (step_reg) begin
            sel = (tbl_rdata[CHAR_W-1:0] == c_reg) ? tbl_rdata[CHAR_W +: SUCC_W]
                                                   : tbl_rdata[CHAR_W+SUCC_W +: SUCC_W];
        end else begin
            sel = tbl_rdata[CHAR_W+2*SUCC_W +: SUCC_W];
        end
    end

    assign take   = pv_reg && active_reg[jd_reg];
    assign s_acc  = take && (sel == SUCC_W'(TABLE_STATES));
    assign s_move = take && (sel != '0) && (sel < used_states);
    assign s_idx  = sel[SW-1:0];

    always_comb begin
        active_next = active_reg;
        nset_next   = nset_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        from_next   = from_reg;
        end1_next   = end1_reg;
        acc_next    = acc_reg;
        chg_next    = chg_reg;
        step_next   = step_reg;
        c_next      = c_reg;
        cnt_next    = cnt_reg;
        pv_next     = issue;
        jd_next     = cnt_reg[SW-1:0];
        ov_next     = ov_reg && !m_tready;
        of_next     = of_reg;
        ofrom_next  = ofrom_reg;
        oto_next    = oto_reg;

        if (cmd.wr_char && status.line_room) begin
            len_next = len_reg + LW'(1);
        end
        if (cmd.line_begin) begin
            from_next = '0;
        end
        if (cmd.next_from) begin
            from_next = from_reg + LW'(1);
        end
        if (cmd.run_init) begin
            active_next = (SUCC_W'(start_state) < used_states)
                        ? (TABLE_STATES'(1) << start_state[SW-1:0]) : '0;
            acc_next    = 1'b0;
            end1_next   = '0;
            pos_next    = from_reg;
        end
        if (cmd.scan_start) begin
            cnt_next  = '0;
            pv_next   = 1'b0;
            chg_next  = 1'b0;
            step_next = cmd.scan_step;
            if (cmd.scan_step) begin
                nset_next = '0;
            end
        end else if (issue) begin
            cnt_next = cnt_reg + SUCC_W'(1);
        end
        if (cmd.char_latch) begin
            c_next = line_rdata;
        end

        // Fold in the entry read last cycle.
        if (s_acc) begin
            acc_next  = 1'b1;
            end1_next = step_reg ? pos_reg + LW'(1) : pos_reg;
        end
        if (s_move) begin
            if (step_reg) begin
                nset_next[s_idx] = 1'b1;
            end else begin
                active_next[s_idx] = 1'b1;
                if (!active_reg[s_idx]) begin
                    chg_next = 1'b1;
                end
            end
        end

        if (cmd.step_done) begin
            active_next = nset_reg;
            pos_next    = pos_reg + LW'(1);
        end

        if (cmd.out_hit) begin
            ov_next    = 1'b1;
            of_next    = 1'b1;
            ofrom_next = FROM_W'(from_reg);
            oto_next   = TO_W'(end1_reg) - TO_W'(1);
            len_next   = '0;
        end
        if (cmd.out_miss) begin
            ov_next    = 1'b1;
            of_next    = 1'b0;
            ofrom_next = '0;
            oto_next   = '0;
            len_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            pv_reg  <= 1'b0;
            ov_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            len_reg <= len_next;
            pv_reg  <= pv_next;
            ov_reg  <= ov_next;
            cnt_reg <= cnt_next;
        end
        active_reg <= active_next;
        nset_reg   <= nset_next;
        pos_reg    <= pos_next;
        from_reg   <= from_next;
        end1_reg   <= end1_next;
        acc_reg    <= acc_next;
        chg_reg    <= chg_next;
        step_reg   <= step_next;
        c_reg      <= c_next;
        jd_reg     <= jd_next;
        of_reg     <= of_next;
        ofrom_reg  <= ofrom_next;
        oto_reg    <= oto_next;
    end

    always_comb begin
        status.scan_busy   = (cnt_reg < used_states) || pv_reg;
        status.eps_changed = chg_reg;
        status.at_line_end = (pos_reg >= len_reg);
        status.next_empty  = (nset_reg == '0);
        status.hit         = acc_reg && (!anchor_end || (end1_reg == len_reg));
        status.last_from   = anchor_start || (from_reg == len_reg);
        status.out_full    = ov_reg && !m_tready;
        status.table_ok    = (SUCC_W'(entry_index) < SUCC_W'(TABLE_STATES));
        status.line_room   = (len_reg < LW'(LINE_LENGTH - 1));
    end

    assign m_tvalid   = ov_reg;
    assign found      = of_reg;
    assign match_from = ofrom_reg;
    assign match_to   = oto_reg;

endmodule

FILE: hdl/nlm_ctrl.sv
// Controller: sequences loading, start positions, epsilon passes and steps.
module nlm_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic                      mode,
    input  logic [nlm_pkg::CHAR_W-1:0] text_char,
    input  nlm_pkg::nlm_status_t      status,
    output nlm_pkg::nlm_cmd_t         cmd
);
    import nlm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_EPS_START, S_EPS, S_CHECK,
        S_CHAR, S_STEP, S_STEP_DONE, S_EVAL
    } state_t;

    state_t state_reg, state_next;
    logic   acc;

    assign s_tready = (state_reg == S_IDLE);
    assign acc      = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (acc) begin
                    if (!mode) begin
                        cmd.wr_table = 1'b1;
                    end else if (text_char != '0) begin
                        cmd.wr_char = 1'b1;
                    end else begin
                        cmd.line_begin = 1'b1;
                        state_next     = S_INIT;
                    end
                end
            end
            S_INIT: begin
                cmd.run_init = 1'b1;
                state_next   = S_EPS_START;
            end
            S_EPS_START: begin
                cmd.scan_start = 1'b1;
                state_next     = S_EPS;
            end
            S_EPS: begin
                cmd.scan_run = 1'b1;
                if (!status.scan_busy) begin
                    state_next = status.eps_changed ? S_EPS_START : S_CHECK;
                end
            end
            S_CHECK: begin
                if (status.at_line_end) begin
                    state_next = S_EVAL;
                end else begin
                    cmd.char_rd = 1'b1;
                    state_next  = S_CHAR;
                end
            end
            S_CHAR: begin
                cmd.char_latch = 1'b1;
                cmd.scan_start = 1'b1;
                cmd.scan_step  = 1'b1;
                state_next     = S_STEP;
            end
            S_STEP: begin
                cmd.scan_run = 1'b1;
                if (!status.scan_busy) begin
                    state_next = S_STEP_DONE;
                end
            end
            S_STEP_DONE: begin
                cmd.step_done = 1'b1;
                state_next    = status.next_empty ? S_EVAL : S_EPS_START;
            end
            S_EVAL: begin
                if (!status.out_full) begin
                    if (status.hit) begin
                        cmd.out_hit = 1'b1;
                        state_next  = S_IDLE;
                    end else if (status.last_from) begin
                        cmd.out_miss = 1'b1;
                        state_next   = S_IDLE;
                    end else begin
                        cmd.next_from = 1'b1;
                        state_next    = S_INIT;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/nfa_line_matcher_top.sv
// Top level of the NFA line matcher: stream ports, APB registers, control and datapath.
//
// Usage:
//   The slave stream carries one item per transfer. tuser[0] selects the kind:
//   0 writes one NFA table entry, 1 supplies one line character. A zero line
//   character ends the line and starts matching; every other item gives no result.
//   The master stream returns one result per line: found, match_from, match_to.
//   Configuration is written through the APB port; the user must do so only while
//   the block is idle, which the block itself does not enforce.
// Sequence:
//   A line end, per start position tried, seeds the set, runs an epsilon closure
//   (passes over the n states in use until the set stops growing), then per
//   character consumed a step scan followed by another closure, and then evaluates.
//   The walk over the table memory, one entry per cycle, sets the pace.
// Reset:
//   aresetn clears the line length, the result valid flag, the controller and the
//   configuration registers; the table and line memories keep whatever they hold.
// Stall:
//   The result waits in an output register; table and character transfers go
//   on meanwhile. A following line end holds at evaluation until it is taken.
module nfa_line_matcher_top #(
    parameter int TABLE_STATES = nlm_pkg::TABLE_STATES_DEF,
    parameter int LINE_LENGTH  = nlm_pkg::LINE_LENGTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // entry_index[5:0], entry_char[13:6], next_on_match[20:14],
    // next_on_miss[27:21], next_epsilon[34:28], text_char[42:35], zero fill
    input  logic [47:0] s_tdata,
    // mode[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // found[0], match_from[8:1], match_to[17:9], zero fill
    output logic [23:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import nlm_pkg::*;

    nlm_cmd_t    cmd;
    nlm_status_t status;

    logic [SUCC_W-1:0]  siu_reg;
    logic [INDEX_W-1:0] start_reg;
    logic               anc_s_reg;
    logic               anc_e_reg;
    logic [SUCC_W-1:0]  used_states;
    logic               cfg_wr;

    logic               found;
    logic [FROM_W-1:0]  match_from;
    logic signed [TO_W-1:0] match_to;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Write the addressed register in the access cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            siu_reg   <= SUCC_W'(1);
            start_reg <= '0;
            anc_s_reg <= 1'b0;
            anc_e_reg <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_STATES_IN_USE: siu_reg   <= pwdata[SUCC_W-1:0];
                REG_START_STATE:   start_reg <= pwdata[INDEX_W-1:0];
                REG_ANCHOR_START:  anc_s_reg <= pwdata[0];
                REG_ANCHOR_END:    anc_e_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_STATES_IN_USE: prdata = 32'(siu_reg);
            REG_START_STATE:   prdata = 32'(start_reg);
            REG_ANCHOR_START:  prdata = 32'(anc_s_reg);
            REG_ANCHOR_END:    prdata = 32'(anc_e_reg);
            default:           prdata = '0;
        endcase
    end

    // Clamp the number of states in use to the table size.
    assign used_states = (siu_reg > SUCC_W'(TABLE_STATES)) ? SUCC_W'(TABLE_STATES) : siu_reg;

    nlm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .mode      (s_tuser[0]),
        .text_char (s_tdata[42:35]),
        .status    (status),
        .cmd       (cmd)
    );

    nlm_datapath #(
        .TABLE_STATES (TABLE_STATES),
        .LINE_LENGTH  (LINE_LENGTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .entry_index   (s_tdata[5:0]),
        .entry_char    (s_tdata[13:6]),
        .next_on_match (s_tdata[20:14]),
        .next_on_miss  (s_tdata[27:21]),
        .next_epsilon  (s_tdata[34:28]),
        .text_char     (s_tdata[42:35]),
        .used_states   (used_states),
        .start_state   (start_reg),
        .anchor_start  (anc_s_reg),
        .anchor_end    (anc_e_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .found         (found),
        .match_from    (match_from),
        .match_to      (match_to)
    );

    assign m_tdata = {6'd0, match_to, match_from, found};

endmodule
